[rtl/core/ttrq_pkg.sv]
// package for the time-stamped tune release queue
// holds state codes, action codes and fixed constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ttrq_pkg;

  localparam int unsigned SampleW = 20;
  localparam int unsigned DivW    = 16;
  localparam logic [SampleW-1:0] UsecPerSecond = 20'd1000000;
  localparam int unsigned EntryW  = 20 + 32 + 32;

  localparam logic [1:0] CfgEnable = 2'd0;
  localparam logic [1:0] CfgStream = 2'd1;
  localparam logic [1:0] CfgDelay  = 2'd2;

  typedef enum logic [1:0] {
    ActFixup = 2'd0,
    ActTune  = 2'd1,
    ActTick  = 2'd2,
    ActLost  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StTune,
    StTickIdx,
    StTickChk,
    StTickRd,
    StDone
  } state_e;

endpackage
`default_nettype wire

[rtl/core/ttrq_ram.sv]
// generic single-port-write, registered-read memory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ttrq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/ttrq_div.sv]
// restoring divider: 1000000 / divisor, one quotient bit per cycle
// depends on ttrq_pkg
`timescale 1ns / 1ps
`default_nettype none
module ttrq_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ttrq_pkg::DivW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [ttrq_pkg::SampleW-1:0]    quot_o
);
  import ttrq_pkg::*;

  logic                busy_q, busy_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [DivW-1:0]     den_q, den_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [SampleW-1:0]  quo_q, quo_d;
  logic [DivW:0]       trial;
  logic                fits;

  always_comb begin
    trial  = {rem_q, quo_q[SampleW-1]};
    fits   = trial >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(SampleW);
      den_d  = (divisor_i == '0) ? DivW'(1) : divisor_i;
      rem_d  = '0;
      quo_d  = UsecPerSecond;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        rem_d = fits ? DivW'(trial - {1'b0, den_q}) : DivW'(trial);
        quo_d = {quo_q[SampleW-2:0], fits};
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule
`default_nettype wire

[rtl/core/timestamped_tune_release_queue.sv]
// top level: sequencer, queue memory and rate divider
// depends on ttrq_pkg, ttrq_ram, ttrq_div
// one word in flight; fixup with new rate waits in StDiv for the divider;
// tune writes in StTune; tick sets the index in StTickIdx, then StTickChk
// and StTickRd per discarded entry, paced by the queue memory read port
// reset: async active low, clears run state, lock, queue pointers and drops
`timescale 1ns / 1ps
`default_nettype none
module timestamped_tune_release_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // msg_stream, lock_tag, sampling_divider, fixup_phase, msg_sample,
  // msg_second, msg_tune, tick_sample, tick_second
  input  wire logic [263:0] s_axis_tdata,
  // action
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tune_valid, tune_value, load_phase, phase_value, running, drop_count
  output logic [127:0]      m_axis_tdata
);
  import ttrq_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_e state_q, state_d;
  logic         en_q, en_d;
  logic [15:0]  sel_q, sel_d;
  logic [9:0]   dly_q, dly_d;
  logic         run_q, run_d;
  logic         lk_q, lk_d;
  logic [31:0]  lv_q, lv_d;
  logic [19:0]  ss_q, ss_d;
  logic [63:0]  ph_q, ph_d;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]  drops_q, drops_d;
  logic [19:0]  ms_q, ms_d;
  logic [31:0]  msec_q, msec_d, mt_q, mt_d;
  logic [19:0]  ts_q, ts_d;
  logic [31:0]  tsec_q, tsec_d;
  logic [20:0]  idx_q, idx_d;
  logic [31:0]  sec_q, sec_d;
  logic         first_q, first_d;
  logic         tv_q, tv_d, lp_q, lp_d;
  logic [23:0]  tval_q, tval_d;
  logic         ov_q, ov_d;
  logic [127:0] od_q, od_d;

  logic div_start, div_done;
  logic [19:0] div_quot;
  logic we;
  logic [PW-1:0] waddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [CW:0] slot_sum;
  logic [20:0] s_sum, t_sum;
  logic [31:0] e_sec, e_tune;
  logic [19:0] e_samp;
  logic        fut, hit, newlock;
  logic [PW-1:0] head_inc;
  action_e act;

  ttrq_ram #(.Width(EntryW), .Depth(QUEUE_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(head_q), .rdata_o(rdata)
  );

  ttrq_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .divisor_i(s_axis_tdata[63:48]),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign act    = action_e'(s_axis_tuser);
  assign e_samp = rdata[19:0];
  assign e_sec  = rdata[51:20];
  assign e_tune = rdata[83:52];
  assign fut    = (e_sec > sec_q) || ((e_sec == sec_q) && (21'(e_samp) > idx_q));
  assign hit    = (e_sec == sec_q) && (21'(e_samp) == idx_q);
  assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign newlock  = !lk_q || (lv_q != s_axis_tdata[47:16]);
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_comb begin
    state_d = state_q; en_d = en_q; sel_d = sel_q; dly_d = dly_q;
    run_d = run_q; lk_d = lk_q; lv_d = lv_q; ss_d = ss_q; ph_d = ph_q;
    head_d = head_q; cnt_d = cnt_q; drops_d = drops_q;
    ms_d = ms_q; msec_d = msec_q; mt_d = mt_q; ts_d = ts_q; tsec_d = tsec_q;
    idx_d = idx_q; sec_d = sec_q; first_d = first_q;
    tv_d = tv_q; lp_d = lp_q; tval_d = tval_q;
    ov_d = ov_q; od_d = od_q;
    div_start = 1'b0; we = 1'b0; waddr = '0; wdata = '0;
    slot_sum = (CW+1)'(head_q) + (CW+1)'(cnt_q);
    if (slot_sum >= (CW+1)'(QUEUE_DEPTH)) slot_sum = slot_sum - (CW+1)'(QUEUE_DEPTH);
    s_sum = 21'(ms_q) + 21'(dly_q);
    t_sum = 21'(ts_q) + 21'd1;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          tv_d = 1'b0; lp_d = 1'b0; tval_d = '0;
          ms_d = s_axis_tdata[147:128]; msec_d = s_axis_tdata[179:148];
          mt_d = s_axis_tdata[211:180]; ts_d = s_axis_tdata[231:212];
          tsec_d = s_axis_tdata[263:232];
          state_d = StDone;
          if (en_q) begin
            unique case (act)
              ActFixup: begin
                if (s_axis_tdata[15:0] == sel_q) begin
                  if (newlock || !run_q) begin
                    lk_d = 1'b1; lv_d = s_axis_tdata[47:16];
                    run_d = 1'b0; head_d = '0; cnt_d = '0;
                    div_start = 1'b1; state_d = StDiv;
                  end
                  ph_d = s_axis_tdata[127:64];
                end
              end
              ActTune: begin
                if (run_q && s_axis_tdata[15:0] == sel_q) begin
                  if (cnt_q >= CW'(QUEUE_DEPTH)) drops_d = drops_q + 32'd1;
                  else state_d = StTune;
                end
              end
              ActTick: begin
                if (run_q && cnt_q != '0) state_d = StTickIdx;
              end
              ActLost: run_d = 1'b0;
              default: ;
            endcase
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          ss_d = div_quot; run_d = 1'b1; state_d = StDone;
        end
      end
      StTune: begin
        we = 1'b1;
        waddr = PW'(slot_sum);
        if (s_sum >= 21'(ss_q)) begin
          wdata = {mt_q, msec_q + 32'd1, 20'(s_sum - 21'(ss_q))};
        end else begin
          wdata = {mt_q, msec_q, 20'(s_sum)};
        end
        cnt_d = cnt_q + CW'(1);
        state_d = StDone;
      end
      StTickIdx: begin
        if (t_sum >= 21'(ss_q)) begin
          idx_d = t_sum - 21'(ss_q); sec_d = tsec_q + 32'd1;
        end else begin
          idx_d = t_sum; sec_d = tsec_q;
        end
        first_d = 1'b1;
        state_d = StTickChk;
      end
      StTickChk: begin
        first_d = 1'b0;
        if (first_q && fut) begin
          state_d = StDone;
        end else begin
          head_d = head_inc; cnt_d = cnt_q - CW'(1);
          if (hit) begin
            tv_d = 1'b1; tval_d = e_tune[23:0];
            lp_d = (idx_q == 21'(dly_q));
            state_d = StDone;
          end else if (cnt_q == CW'(1)) begin
            state_d = StDone;
          end else begin
            state_d = StTickRd;
          end
        end
      end
      StTickRd: state_d = StTickChk;
      StDone: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = {5'd0, drops_q, run_q & en_q, lp_q ? ph_q : 64'd0, lp_q,
                  tval_q, tv_q};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgEnable: begin
          if (cfg_wdata_i[0] && !en_q) begin
            run_d = 1'b0; head_d = '0; cnt_d = '0;
          end
          en_d = cfg_wdata_i[0];
        end
        CfgStream: sel_d = cfg_wdata_i;
        CfgDelay:  dly_d = cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; en_q <= 1'b0; sel_q <= 16'd123; dly_q <= 10'd4;
      run_q <= 1'b0; lk_q <= 1'b0; lv_q <= '0; ss_q <= '0; ph_q <= '0;
      head_q <= '0; cnt_q <= '0; drops_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; en_q <= en_d; sel_q <= sel_d; dly_q <= dly_d;
      run_q <= run_d; lk_q <= lk_d; lv_q <= lv_d; ss_q <= ss_d; ph_q <= ph_d;
      head_q <= head_d; cnt_q <= cnt_d; drops_q <= drops_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ms_q <= ms_d; msec_q <= msec_d; mt_q <= mt_d; ts_q <= ts_d; tsec_q <= tsec_d;
    idx_q <= idx_d; sec_q <= sec_d; first_q <= first_d;
    tv_q <= tv_d; lp_q <= lp_d; tval_q <= tval_d; od_q <= od_d;
  end

endmodule
`default_nettype wire

[verif/timestamped_tune_release_queue_tb.sv]
// self-checking bench for the time-stamped tune release queue
// predicts every result word in a local model; depends on ttrq_pkg and the rtl
`timescale 1ns / 1ps
`default_nettype none
module timestamped_tune_release_queue_tb;
  import ttrq_pkg::*;

  localparam int Depth = 8;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [31:0] tick_second;
    logic [19:0] tick_sample;
    logic [31:0] msg_tune;
    logic [31:0] msg_second;
    logic [19:0] msg_sample;
    logic [63:0] acc_phase;
    logic [15:0] rate_div;
    logic [31:0] lock_tag;
    logic [15:0] msg_stream;
  } word_in_t;

  typedef struct packed {
    logic [31:0] drop_count;
    logic        running;
    logic [63:0] phase_value;
    logic        load_phase;
    logic [23:0] tune_value;
    logic        tune_valid;
  } word_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [263:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  timestamped_tune_release_queue #(.QUEUE_DEPTH(Depth)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic        p_enable;
  logic [15:0] p_stream;
  logic [9:0]  p_delay;
  logic        p_run, p_lock_known;
  logic [31:0] p_lock;
  logic [19:0] p_rate;
  logic [63:0] p_phase;
  logic [19:0] q_sample [Depth];
  logic [31:0] q_second [Depth];
  logic [31:0] q_tune [Depth];
  int unsigned q_head, q_count;
  logic [31:0] p_drops;

  word_out_t expected_words[$];
  int errors = 0;
  int releases = 0, loads = 0;
  bit rx_on = 1'b1, tx_idle_on = 1'b1;
  bit hold_req = 1'b0;
  longint cycles = 0;

  task automatic predict_cfg(input logic [1:0] idx, input logic [15:0] v);
    if (idx == CfgEnable) begin
      if (v[0] && !p_enable) begin
        p_run = 1'b0;
        q_head = 0;
        q_count = 0;
      end
      p_enable = v[0];
    end else if (idx == CfgStream) begin
      p_stream = v;
    end else if (idx == CfgDelay) begin
      p_delay = v[9:0];
    end
  endtask

  function automatic word_out_t release_step(input action_e act, input word_in_t w);
    word_out_t r;
    logic [31:0] s, sec;
    int unsigned h, slot;
    logic [15:0] dv;
    r = '0;
    if (p_enable) begin
      case (act)
        ActFixup: begin
          if (w.msg_stream == p_stream) begin
            if (!p_lock_known || p_lock != w.lock_tag) begin
              p_run = 1'b0;
              p_lock_known = 1'b1;
              p_lock = w.lock_tag;
              q_head = 0;
              q_count = 0;
            end
            if (!p_run) begin
              dv = (w.rate_div == 0) ? 16'd1 : w.rate_div;
              p_rate = 20'(32'd1000000 / dv);
              q_head = 0;
              q_count = 0;
              p_run = 1'b1;
            end
            p_phase = w.acc_phase;
          end
        end
        ActTune: begin
          if (p_run && w.msg_stream == p_stream) begin
            if (q_count >= Depth) begin
              p_drops++;
            end else begin
              s = 32'(w.msg_sample) + 32'(p_delay);
              sec = w.msg_second;
              slot = (q_head + q_count) % Depth;
              if (s >= 32'(p_rate)) begin
                s -= 32'(p_rate);
                sec++;
              end
              q_sample[slot] = s[19:0];
              q_second[slot] = sec;
              q_tune[slot] = w.msg_tune;
              q_count++;
            end
          end
        end
        ActTick: begin
          if (p_run && q_count > 0) begin
            s = 32'(w.tick_sample) + 1;
            sec = w.tick_second;
            h = q_head;
            if (s >= 32'(p_rate)) begin
              s -= 32'(p_rate);
              sec++;
            end
            if (!(q_second[h] > sec || (q_second[h] == sec && 32'(q_sample[h]) > s))) begin
              while (q_count > 0) begin
                h = q_head;
                q_head = (q_head + 1) % Depth;
                q_count--;
                if (q_second[h] == sec && 32'(q_sample[h]) == s) begin
                  r.tune_valid = 1'b1;
                  r.tune_value = q_tune[h][23:0];
                  if (s == 32'(p_delay)) begin
                    r.load_phase = 1'b1;
                    r.phase_value = p_phase;
                  end
                  break;
                end
              end
            end
          end
        end
        default: p_run = 1'b0;
      endcase
    end
    r.running = p_run && p_enable;
    r.drop_count = p_drops;
    return r;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    word_out_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(word_out_t)-1:0];
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.tune_valid) releases++;
        if (got.load_phase) loads++;
        if (got.tune_valid !== exp_w.tune_valid) begin
          $error("tune_valid exp %0h got %0h", exp_w.tune_valid, got.tune_valid); errors++;
        end
        if (got.tune_value !== exp_w.tune_value) begin
          $error("tune_value exp %0h got %0h", exp_w.tune_value, got.tune_value); errors++;
        end
        if (got.load_phase !== exp_w.load_phase) begin
          $error("load_phase exp %0h got %0h", exp_w.load_phase, got.load_phase); errors++;
        end
        if (got.phase_value !== exp_w.phase_value) begin
          $error("phase_value exp %0h got %0h", exp_w.phase_value, got.phase_value);
          errors++;
        end
        if (got.running !== exp_w.running) begin
          $error("running exp %0h got %0h", exp_w.running, got.running); errors++;
        end
        if (got.drop_count !== exp_w.drop_count) begin
          $error("drop_count exp %0h got %0h", exp_w.drop_count, got.drop_count); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    predict_cfg(idx, v);
  endtask

  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // sends one word; the model sees it at acceptance
  task automatic send_word(input action_e act, input word_in_t w);
    int n;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= 264'(w);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_words.push_back(release_step(act, w));
  endtask

  function automatic word_in_t rand_word();
    word_in_t w;
    w.msg_stream = 16'($urandom);
    w.lock_tag = $urandom;
    w.rate_div = 16'($urandom);
    w.acc_phase = {$urandom, $urandom};
    w.msg_sample = 20'($urandom);
    w.msg_second = $urandom;
    w.msg_tune = $urandom;
    w.tick_sample = 20'($urandom);
    w.tick_second = $urandom;
    return w;
  endfunction

  // well-formed session: fixup, then tunes interleaved with ticks walking past them
  task automatic session(input int len, input bit lossy);
    word_in_t w;
    logic [31:0] sec, tag;
    logic [19:0] base;
    int unsigned rate, idx, div;
    int sent;
    div = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 200);
    rate = 1000000 / ((div == 0) ? 1 : div);
    sec = ($urandom_range(0, 5) == 0) ? 32'hffff_ffff : $urandom;
    tag = ($urandom_range(0, 1) == 0) ? p_lock : $urandom;
    w = rand_word();
    w.msg_stream = p_stream;
    w.lock_tag = tag;
    w.rate_div = div[15:0];
    send_word(ActFixup, w);
    idx = $urandom_range(0, (rate > 40) ? rate - 40 : 0);
    if ($urandom_range(0, 3) == 0 && rate > p_delay + 2) idx = p_delay - 1 + rate;
    base = 20'(idx % rate);
    sent = 0;
    while (sent < len) begin
      w = rand_word();
      if ($urandom_range(0, 2) != 0) begin
        w.msg_stream = p_stream;
        w.msg_second = sec;
        w.msg_sample = 20'((base + $urandom_range(0, 12)) % rate);
        if ($urandom_range(0, 9) == 0) w.msg_sample = 20'($urandom);
        send_word(ActTune, w);
      end else begin
        w.tick_second = sec;
        w.tick_sample = base;
        if ($urandom_range(0, 15) == 0) w.tick_sample = 20'($urandom);
        send_word(ActTick, w);
        base = base + 1;
        if (base >= rate) begin
          base = 0;
          sec++;
        end
      end
      if (lossy && $urandom_range(0, 40) == 0) send_word(ActLost, rand_word());
      sent++;
    end
  endtask

  typedef struct {
    action_e   act;
    word_in_t  w;
    bit        known;
    word_out_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    word_out_t got_exp;
    word_in_t w;
    int total;
    p_enable = 0; p_stream = 16'd123; p_delay = 10'd4;
    p_run = 0; p_lock_known = 0; p_lock = '0; p_rate = '0; p_phase = '0;
    q_head = 0; q_count = 0; p_drops = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled: everything ignored, state reported as after reset
    row.known = 1; row.res = '0;
    row.act = ActFixup; row.w = '1; row.w.msg_stream = 16'd123; rows.push_back(row);
    row.act = ActTune; row.w = '0; rows.push_back(row);
    row.act = ActTick; row.w = '1; rows.push_back(row);
    row.act = ActLost; row.w = '0; rows.push_back(row);
    foreach (rows[i]) begin
      send_word(rows[i].act, rows[i].w);
      got_exp = expected_words[$];
      if (rows[i].known && got_exp !== rows[i].res) begin
        $error("model disagrees with table row %0d", i); errors++;
      end
    end
    drain_idle();
    write_reg(CfgEnable, 16'd1);
    write_reg(CfgStream, 16'hffff);
    write_reg(CfgDelay, 16'h03ff);

    // enabled: foreign stream, tune outside run, zero divider, full queue,
    // release with phase load, second wrap, timing lost
    rows.delete();
    row.known = 0; row.res = '0;
    row.act = ActFixup; row.w = '0; row.w.msg_stream = 16'h0; rows.push_back(row);
    row.act = ActTune; row.w = '0; row.w.msg_stream = 16'hffff; rows.push_back(row);
    row.act = ActFixup; row.w = '1; row.w.rate_div = 16'd0; rows.push_back(row);
    for (int i = 0; i < 10; i++) begin
      row.act = ActTune; row.w = '1; row.w.msg_sample = 20'(i); rows.push_back(row);
    end
    row.act = ActTick; row.w = '0; row.w.tick_sample = 20'd1022; rows.push_back(row);
    row.w.tick_second = 32'hffff_ffff; rows.push_back(row);
    row.w.tick_sample = 20'hfffff; rows.push_back(row);
    row.act = ActTick; row.w = '1; rows.push_back(row);
    row.act = ActLost; row.w = '0; rows.push_back(row);
    row.act = ActTune; row.w = '1; row.w.msg_stream = 16'hffff; rows.push_back(row);
    foreach (rows[i]) begin
      send_word(rows[i].act, rows[i].w);
      got_exp = expected_words[$];
      if (rows[i].known && got_exp !== rows[i].res) begin
        $error("model disagrees with table row %0d", i); errors++;
      end
    end
    drain_idle();
    write_reg(CfgDelay, 16'd0);
    write_reg(CfgStream, 16'd0);

    total = 0;
    while (total < 880) begin
      int len;
      len = $urandom_range(10, 40);
      if (total > 200 && total < 260) hold_req = 1'b1;
      if (total > 760) begin
        rx_on = 1'b0;
        tx_idle_on = 1'b0;
      end
      if ($urandom_range(0, 6) == 0) begin
        drain_idle();
        case ($urandom_range(0, 3))
          0: write_reg(CfgDelay, 16'($urandom_range(0, 1023)));
          1: write_reg(CfgDelay, 16'($urandom_range(0, 8)));
          2: write_reg(CfgStream, 16'($urandom));
          default: begin
            write_reg(CfgEnable, 16'd0);
            if ($urandom_range(0, 1)) begin
              send_word(ActTick, rand_word());
              drain_idle();
            end
            write_reg(CfgEnable, 16'd1);
          end
        endcase
      end
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < 5; i++) begin
          w = rand_word();
          if ($urandom_range(0, 1)) w.msg_stream = p_stream;
          send_word(action_e'($urandom_range(0, 3)), w);
        end
        total += 5;
      end
      session(len, $urandom_range(0, 1));
      total += len;
    end

    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d input words over sessions and register changes", total);
    $display("%0d tunes released, %0d phase loads, %0d drops", releases, loads, p_drops);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
